FILE: design/lds_pkg.sv
// Shared types and constants for the line delimiter splitter.
package lds_pkg;

	// Result kinds carried on the output channel
	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_LINE     = 2'd1,
		KIND_OVERFLOW = 2'd2
	} lds_kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DELIM_BYTES  = 2'd0,
		REG_DELIM_LENGTH = 2'd1,
		REG_BUFFER_SIZE  = 2'd2,
		REG_UNUSED       = 2'd3
	} lds_reg_t;

	// Register reset values
	localparam logic [31:0] DELIM_BYTES_RST = 32'h0000_0A0D;
	localparam int          DELIM_LEN_RST   = 2;
	localparam int          BUF_SIZE_RST    = 65536;

	// Longest delimiter the window ever compares
	localparam int DELIM_HW_MAX = 4;

	// Per-cycle control handed to every window cell
	typedef struct packed {
		logic en;        // input transfer this cycle
		logic shift;     // oldest byte leaves, row moves toward cell 0
		logic put_here;  // new byte lands in this cell
		logic put_next;  // new byte lands in the right-hand neighbor
		logic active;    // cell lies inside the delimiter length
	} lds_cell_ctl_t;

endpackage

FILE: design/lds_cell.sv
// One window cell: holds a byte, compares it to its delimiter byte, shifts left.
module lds_cell
	import lds_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  lds_cell_ctl_t ctl,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    nbr_byte,
	input  logic [7:0]    delim_byte,
	input  logic          match_in,
	output logic [7:0]    held_byte,
	output logic [7:0]    view_byte,
	output logic          match_out
);

	logic [7:0] byte_q;
	logic [7:0] byte_d;

	// Window contents once the incoming byte is written
	assign view_byte = ctl.put_here ? rx_byte : byte_q;

	// Match chain: cells past the delimiter length pass it through
	assign match_out = match_in & (~ctl.active | (view_byte == delim_byte));

	// Next contents: take the neighbor's view when the row shifts
	always_comb begin
		if (ctl.shift) begin
			byte_d = ctl.put_next ? rx_byte : nbr_byte;
		end else begin
			byte_d = view_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.en) begin
			byte_q <= byte_d;
		end
	end

	assign held_byte = byte_q;

endmodule

FILE: design/line_delimiter_splitter.sv
// Top level of the line delimiter splitter: config, window cell row, counters, result register.
//
// Splits a byte stream into lines at a 1 to 4 byte delimiter (CR LF after reset).
// Each transfer in carries one byte and yields at most one result: a released
// data byte, a line end with its length and zero-byte flag, or an overflow that
// drops the pending line once released plus windowed bytes reach buffer_size.
// The delimiter window is a row of byte cells that compare in parallel and
// shift toward the oldest position; the compare chain, the pending-count add and
// compare are all combinational, so one byte is taken every cycle while the input
// is not stalled, and each result is registered. Input stalls only while a result
// sits in the output register and the output side stalls. Configuration writes
// take effect on the next cycle; writing the delimiter length empties the window
// and drops the pending line without a result.
module line_delimiter_splitter
	import lds_pkg::*;
#(
	parameter int DELIM_MAX  = 4,
	parameter int MAX_BUFFER = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  data_byte,
	output logic [16:0] line_length,
	output logic        line_had_zero
);

	localparam int LEN_MAX = (DELIM_MAX < DELIM_HW_MAX) ? DELIM_MAX : DELIM_HW_MAX;
	localparam int FILL_W  = $clog2(LEN_MAX + 1);
	localparam int CNT_W   = $clog2(MAX_BUFFER + 1);
	localparam int CMP_W   = (CNT_W > 17) ? CNT_W : 17;
	localparam int LEN_RST = (DELIM_LEN_RST > LEN_MAX) ? LEN_MAX : DELIM_LEN_RST;
	localparam int CAP_RST = (BUF_SIZE_RST > MAX_BUFFER) ? MAX_BUFFER : BUF_SIZE_RST;
	localparam int CAP_MIN = DELIM_MAX + 1;

	// Config registers (length and capacity stored already clamped)
	logic [31:0]       delim_q;
	logic [FILL_W-1:0] len_q;
	logic [CNT_W-1:0]  cap_q;

	// Line state
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  released_q;
	logic              zero_q;

	// Result register
	logic              out_valid_q;
	lds_kind_t         kind_q;
	logic [7:0]        data_q;
	logic [16:0]       length_q;
	logic              had_zero_q;

	logic              accept;
	logic [FILL_W-1:0] fill_w;
	logic              full;
	logic              match;
	logic              ovf;
	logic              rel;
	logic [CNT_W:0]    pend;
	logic [7:0]        rel_byte;
	logic [16:0]       length_out;
	logic [CNT_W+16:0] length_ext;

	logic [2:0]        len_raw;
	logic [2:0]        len_one;
	logic [FILL_W-1:0] len_eff;
	logic [CMP_W-1:0]  buf_raw;
	logic [CMP_W-1:0]  buf_eff;

	logic [7:0]        held   [LEN_MAX];
	logic [7:0]        view   [LEN_MAX];
	logic              chain  [LEN_MAX+1];

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Clamp incoming config values
	always_comb begin
		len_raw = cfg_data[2:0];
		len_one = (len_raw == 3'd0) ? 3'd1 : len_raw;
		len_eff = (int'(len_one) > LEN_MAX) ? FILL_W'(LEN_MAX) : FILL_W'(len_one);
		buf_raw = CMP_W'(cfg_data[16:0]);
		if (buf_raw < CMP_W'(CAP_MIN)) begin
			buf_eff = CMP_W'(CAP_MIN);
		end else if (buf_raw > CMP_W'(MAX_BUFFER)) begin
			buf_eff = CMP_W'(MAX_BUFFER);
		end else begin
			buf_eff = buf_raw;
		end
	end

	// Window write position and step decisions
	always_comb begin
		fill_w = (fill_q >= len_q) ? (len_q - FILL_W'(1)) : fill_q;
		full   = ((fill_w + FILL_W'(1)) == len_q);
		match  = full & chain[LEN_MAX];
		pend   = {1'b0, released_q} + (CNT_W+1)'(fill_w) + (CNT_W+1)'(1);
		ovf    = ~match & (pend >= {1'b0, cap_q});
		rel    = full & ~match & ~ovf;
	end

	assign rel_byte = view[0];
	assign chain[0] = 1'b1;

	// Row of window cells
	for (genvar i = 0; i < LEN_MAX; i++) begin : g_cell
		lds_cell_ctl_t ctl;
		logic [7:0]    nbr;

		assign ctl.en       = accept;
		assign ctl.shift    = rel;
		assign ctl.put_here = (fill_w == FILL_W'(i));
		assign ctl.put_next = (fill_w == FILL_W'(i + 1));
		assign ctl.active   = (FILL_W'(i) < len_q);

		if (i + 1 < LEN_MAX) begin : g_nbr
			assign nbr = held[i+1];
		end else begin : g_end
			assign nbr = 8'd0;
		end

		lds_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.rx_byte    (rx_byte),
			.nbr_byte   (nbr),
			.delim_byte (delim_q[8*i +: 8]),
			.match_in   (chain[i]),
			.held_byte  (held[i]),
			.view_byte  (view[i]),
			.match_out  (chain[i+1])
		);
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_BYTES_RST;
			len_q   <= FILL_W'(LEN_RST);
			cap_q   <= CNT_W'(CAP_RST);
		end else if (cfg_we) begin
			unique case (lds_reg_t'(cfg_index))
				REG_DELIM_BYTES:  delim_q <= cfg_data;
				REG_DELIM_LENGTH: len_q   <= len_eff;
				REG_BUFFER_SIZE:  cap_q   <= CNT_W'(buf_eff);
				default:          ;
			endcase
		end
	end

	// Line state: fill level, released count, zero flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			released_q <= '0;
			zero_q     <= 1'b0;
		end else if (cfg_we && lds_reg_t'(cfg_index) == REG_DELIM_LENGTH) begin
			fill_q     <= '0;
			released_q <= '0;
			zero_q     <= 1'b0;
		end else if (accept) begin
			priority if (match || ovf) begin
				fill_q     <= '0;
				released_q <= '0;
				zero_q     <= 1'b0;
			end else if (rel) begin
				fill_q     <= fill_w;
				released_q <= released_q + CNT_W'(1);
				zero_q     <= zero_q | (rel_byte == 8'd0);
			end else begin
				fill_q     <= fill_w + FILL_W'(1);
			end
		end
	end

	// Fit the count to the 17-bit length field
	assign length_ext = {17'd0, released_q};
	assign length_out = length_ext[16:0];

	// Result register: loads on an input transfer, drains on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= match | ovf | rel;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (match) begin
				kind_q     <= KIND_LINE;
				data_q     <= 8'd0;
				length_q   <= length_out;
				had_zero_q <= zero_q;
			end else if (ovf) begin
				kind_q     <= KIND_OVERFLOW;
				data_q     <= 8'd0;
				length_q   <= 17'd0;
				had_zero_q <= 1'b0;
			end else begin
				kind_q     <= KIND_DATA;
				data_q     <= rel_byte;
				length_q   <= 17'd0;
				had_zero_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign data_byte     = data_q;
	assign line_length   = length_q;
	assign line_had_zero = had_zero_q;

	logic unused_held;
	assign unused_held = ^held[0];

endmodule

FILE: sim/line_split_checker.sv
// Result checker for the line delimiter splitter: tracks transfers, predicts and compares.
`timescale 1ns / 1ps

module line_split_checker
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  data_byte,
	input  logic [16:0] line_length,
	input  logic        line_had_zero,
	output int          mismatches,
	output int          results_waiting
);

	localparam int BUF_CEILING = 65536;

	typedef struct {
		lds_kind_t   kind;
		logic [7:0]  data;
		logic [16:0] length;
		logic        had_zero;
	} split_result_t;

	split_result_t expected_results[$];

	// predicted block state
	logic [7:0]  window [DELIM_HW_MAX];
	int unsigned window_fill;
	int unsigned released;
	logic        zero_seen;

	// predicted register contents
	logic [31:0] delim_bytes;
	logic [2:0]  delim_count;
	logic [16:0] buf_size;

	function automatic void drop_line();
		window_fill = 0;
		released = 0;
		zero_seen = 1'b0;
	endfunction

	// one received byte through the window: line end, overflow, released byte, or none while the window fills
	task automatic take_byte(input logic [7:0] b);
		int unsigned span;
		int unsigned cap;
		bit hit;
		split_result_t r;
		span = int'(delim_count);
		if (span < 1) span = 1;
		if (span > DELIM_HW_MAX) span = DELIM_HW_MAX;
		cap = int'(buf_size);
		if (cap < DELIM_HW_MAX + 1) cap = DELIM_HW_MAX + 1;
		if (cap > BUF_CEILING) cap = BUF_CEILING;

		if (window_fill >= span) window_fill = span - 1;
		window[window_fill] = b;
		window_fill++;

		r.kind = KIND_DATA;
		r.data = '0;
		r.length = '0;
		r.had_zero = 1'b0;

		hit = (window_fill == span);
		for (int i = 0; i < DELIM_HW_MAX; i++) begin
			if (i < span && window[i] != delim_bytes[8*i +: 8]) hit = 1'b0;
		end

		// a delimiter match beats overflow in the same step
		if (hit) begin
			r.kind = KIND_LINE;
			r.length = released[16:0];
			r.had_zero = zero_seen;
			drop_line();
			expected_results.push_back(r);
		end else if (released + window_fill >= cap) begin
			r.kind = KIND_OVERFLOW;
			drop_line();
			expected_results.push_back(r);
		end else if (window_fill == span) begin
			r.data = window[0];
			for (int i = 1; i < DELIM_HW_MAX; i++) begin
				if (i < span) window[i-1] = window[i];
			end
			window_fill = span - 1;
			released++;
			if (r.data == 8'h00) zero_seen = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		split_result_t want;
		if (!arst_n) begin
			delim_bytes = DELIM_BYTES_RST;
			delim_count = 3'(DELIM_LEN_RST);
			buf_size = 17'(BUF_SIZE_RST);
			for (int i = 0; i < DELIM_HW_MAX; i++) window[i] = '0;
			drop_line();
			expected_results.delete();
		end else begin
			// output transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: kind %0d byte %02h length %0d zero %0b",
						$time, result_kind, data_byte, line_length, line_had_zero);
				end else begin
					want = expected_results.pop_front();
					if (result_kind !== want.kind || data_byte !== want.data ||
						line_length !== want.length || line_had_zero !== want.had_zero) begin
						mismatches++;
						$display("%0t: mismatch: expected kind %0d byte %02h length %0d zero %0b",
							$time, want.kind, want.data, want.length, want.had_zero);
						$display("%0t:           actual kind %0d byte %02h length %0d zero %0b",
							$time, result_kind, data_byte, line_length, line_had_zero);
					end
				end
			end

			// register writes; a length write discards the pending line
			if (cfg_we) begin
				case (lds_reg_t'(cfg_index))
					REG_DELIM_BYTES: delim_bytes = cfg_data;
					REG_DELIM_LENGTH: begin
						delim_count = cfg_data[2:0];
						drop_line();
					end
					REG_BUFFER_SIZE: buf_size = cfg_data[16:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) take_byte(rx_byte);
		end
		results_waiting = expected_results.size();
	end

endmodule

FILE: sim/line_delimiter_splitter_tb.sv
// Testbench top for the line delimiter splitter: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module line_delimiter_splitter_tb;
	import lds_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_BYTES    = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DELIM_BYTES;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte;
	logic [16:0] line_length;
	logic        line_had_zero;

	int fail_count;
	int results_waiting;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;

	// stimulus copy of the delimiter, used to shape lines
	logic [31:0] cur_delim = DELIM_BYTES_RST;
	int          cur_len = DELIM_LEN_RST;

	line_delimiter_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.line_length(line_length),
		.line_had_zero(line_had_zero)
	);

	line_split_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.line_length(line_length),
		.line_had_zero(line_had_zero),
		.mismatches(fail_count),
		.results_waiting(results_waiting)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (!gaps_on || r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int delim_span();
		if (cur_len < 1) return 1;
		if (cur_len > DELIM_HW_MAX) return DELIM_HW_MAX;
		return cur_len;
	endfunction

	// line content biased toward delimiter bytes, zero and all-ones
	function automatic logic [7:0] pick_byte();
		int r;
		int k;
		r = $urandom_range(99);
		k = $urandom_range(3);
		if (r < 35) return cur_delim[8*k +: 8];
		if (r < 45) return 8'h00;
		if (r < 50) return 8'hFF;
		return 8'($urandom);
	endfunction

	// one input transfer, after a random gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// bytes packed with the first one in the top of the vector
	task automatic send_run(input logic [127:0] s, input int n);
		for (int i = 0; i < n; i++) send_byte(s[8*(n-1-i) +: 8]);
	endtask

	task automatic send_delim(input int count);
		for (int i = 0; i < count; i++) send_byte(cur_delim[8*i +: 8]);
	endtask

	// wait for every expected result, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input lds_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DELIM_BYTES) cur_delim = val;
		if (idx == REG_DELIM_LENGTH) cur_len = int'(val[2:0]);
	endtask

	// random settings, then lines: mostly terminated, some with a broken or missing delimiter
	task automatic random_phase(input int bytes_wanted, input bit squeeze);
		logic [31:0] word;
		int r;
		int n;
		int span;
		int sent;
		gaps_on = ($urandom_range(3) != 0);

		if ($urandom_range(3) != 0) begin
			for (int i = 0; i < 4; i++) begin
				case ($urandom_range(4))
					0: word[8*i +: 8] = 8'h0D;
					1: word[8*i +: 8] = 8'h0A;
					2: word[8*i +: 8] = 8'h00;
					3: word[8*i +: 8] = 8'h61;
					default: word[8*i +: 8] = 8'($urandom);
				endcase
			end
			write_reg(REG_DELIM_BYTES, word);
		end

		r = $urandom_range(99);
		word = $urandom;
		if (r < 80) word[2:0] = 3'($urandom_range(4, 1));
		else if (r < 90) word[2:0] = 3'd0;
		else word[2:0] = 3'($urandom_range(7, 5));
		write_reg(REG_DELIM_LENGTH, word);

		r = $urandom_range(99);
		word = $urandom;
		if (r < 55) word[16:0] = 17'($urandom_range(40, 5));
		else if (r < 65) word[16:0] = 17'($urandom_range(4, 0));
		else if (r < 75) word[16:0] = 17'($urandom_range(131071, 65537));
		else if (r < 85) word[16:0] = 17'd65536;
		else word[16:0] = 17'($urandom_range(2000, 41));
		write_reg(REG_BUFFER_SIZE, word);

		if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);

		if (squeeze) hold_req = 1'b1;
		sent = 0;
		while (sent < bytes_wanted) begin
			span = delim_span();
			n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
			for (int i = 0; i < n; i++) send_byte(pick_byte());
			sent += n;
			r = $urandom_range(99);
			if (r < 80) begin
				send_delim(span);
				sent += span;
			end else if (r < 92) begin
				n = $urandom_range(span - 1);
				send_delim(n);
				sent += n;
			end
		end
		drain();
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (left > 0) begin
				left--;
			end else begin
				left = idle_len();
				out_stall <= (left > 0);
				if (left > 0) left--;
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// CR LF: zero and all-ones bytes, an empty line, a lone CR inside a line
		send_run(80'h00FF_410D_0A0D_0A0D_0D0A, 10);
		drain();

		// delimiter length zero acts as one byte
		write_reg(REG_DELIM_BYTES, 32'h4433_2211);
		write_reg(REG_DELIM_LENGTH, 32'd0);
		send_run(24'h22_1111, 3);
		drain();

		// length above the window acts as four; a length write drops the partial line
		write_reg(REG_DELIM_LENGTH, 32'd7);
		send_run(24'h55_1122, 3);
		drain();
		write_reg(REG_DELIM_LENGTH, 32'd4);
		send_run(32'h1122_3344, 4);
		drain();

		// delimiter completes exactly at the buffer limit: the line end wins
		write_reg(REG_BUFFER_SIZE, 32'd6);
		send_run(48'h6162_1122_3344, 6);
		drain();

		// size below the floor acts as five
		write_reg(REG_BUFFER_SIZE, 32'd0);
		send_run(40'h6162_6364_65, 5);
		drain();

		// shrinking the buffer below the pending count overflows on the next byte
		write_reg(REG_BUFFER_SIZE, 32'd100);
		send_run(48'h7A7A_7A7A_7A7A, 6);
		drain();
		write_reg(REG_BUFFER_SIZE, 32'd5);
		send_byte(8'h7A);
		drain();

		// unused index has no effect
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_run(32'h1122_3344, 4);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) random_phase(PHASE_BYTES, p == 3);

		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
